/* design/llqm_pkg.sv */
// ----------------------------------------------------------------------------
// llqm_pkg
// Shared types, sizes and command codes for the linked-list queue manager.
// ----------------------------------------------------------------------------
package llqm_pkg;

   localparam int POOL_ENTRIES = 64;
   localparam int NUM_QUEUES   = 8;

   localparam int CMD_W   = 3;
   localparam int QID_W   = 3;
   localparam int ENTRY_W = $clog2(POOL_ENTRIES);
   localparam int LINK_W  = $clog2(POOL_ENTRIES + 1);
   localparam int LEN_W   = LINK_W;
   localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   typedef logic [LINK_W-1:0]  link_type;
   typedef logic [ENTRY_W-1:0] entry_type;
   typedef logic [QIDX_W-1:0]  qidx_type;
   typedef logic [LEN_W-1:0]   len_type;

   // end-of-list marker
   localparam link_type LINK_NONE = link_type'(POOL_ENTRIES);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 3'd0,
      CMD_RELEASE = 3'd1,
      CMD_POP     = 3'd2,
      CMD_INSERT  = 3'd3,
      CMD_APPEND  = 3'd4,
      CMD_REMOVE  = 3'd5,
      CMD_LENGTH  = 3'd6
   } cmd_type;

   // classified command passed from front to back
   typedef struct packed {
      cmd_type   cmd;
      qidx_type  qidx;
      entry_type entry;
      logic      reject;
   } cmd_pkt_type;

   function automatic logic link_valid(link_type l);
      return l < link_type'(POOL_ENTRIES);
   endfunction

endpackage

/* design/llqm_ram.sv */
// ----------------------------------------------------------------------------
// llqm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/llqm_front.sv */
// ----------------------------------------------------------------------------
// llqm_front
// Accepts command beats, range-checks them and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module llqm_front
   import llqm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [QID_W-1:0]   req_queue_id,
   input  logic [ENTRY_W-1:0] req_entry,
   output logic               pkt_valid,
   input  logic               pkt_pop,
   output cmd_pkt_type        pkt
);

   localparam int FQ_DEPTH = 2;
   localparam int FQ_AW    = $clog2(FQ_DEPTH);

   cmd_pkt_type              fq_ff [FQ_DEPTH];
   cmd_pkt_type              new_pkt;
   logic [FQ_AW-1:0]         wptr_ff, wptr_in;
   logic [FQ_AW-1:0]         rptr_ff, rptr_in;
   logic [FQ_AW:0]           count_ff, count_in;
   logic                     push;
   logic                     pop;
   logic                     q_ok;
   logic                     e_ok;
   cmd_type                  cmd;

   assign cmd  = cmd_type'(req_command);
   assign q_ok = int'(req_queue_id) < NUM_QUEUES;
   assign e_ok = int'(req_entry) < POOL_ENTRIES;

   always_comb begin
      new_pkt.cmd   = cmd;
      new_pkt.qidx  = req_queue_id[QIDX_W-1:0];
      new_pkt.entry = req_entry;
      case (cmd)
         CMD_ALLOC:   new_pkt.reject = 1'b0;
         CMD_RELEASE: new_pkt.reject = !e_ok;
         CMD_POP,
         CMD_LENGTH:  new_pkt.reject = !q_ok;
         CMD_INSERT,
         CMD_APPEND,
         CMD_REMOVE:  new_pkt.reject = !(q_ok && e_ok);
         default:     new_pkt.reject = 1'b1;
      endcase
   end

   assign req_ready = count_ff < (FQ_AW+1)'(FQ_DEPTH);
   assign push      = req_valid && req_ready;
   assign pkt_valid = count_ff != '0;
   assign pop       = pkt_pop && pkt_valid;
   assign pkt       = fq_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fq_ff[wptr_ff] <= new_pkt;
      end
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* design/llqm_back.sv */
// ----------------------------------------------------------------------------
// llqm_back
// Executes queued commands against the link RAM and head/tail registers.
// ----------------------------------------------------------------------------
module llqm_back
   import llqm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               pkt_valid,
   output logic               pkt_pop,
   input  cmd_pkt_type        pkt,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ENTRY_W-1:0] rsp_entry_out,
   output logic               rsp_ok,
   output logic [LEN_W-1:0]   rsp_queue_length
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POPRD,
      ST_APP2,
      ST_RMHEAD,
      ST_WALK,
      ST_RMFIX,
      ST_RMCLR,
      ST_FIN
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   qidx_type          qidx_ff, qidx_in;
   entry_type         entry_ff, entry_in;
   logic              rej_ff, rej_in;
   link_type          t_ff, t_in;
   len_type           cnt_ff, cnt_in;
   link_type          free_head_ff, free_head_in;
   link_type          head_ff [NUM_QUEUES];
   link_type          head_in [NUM_QUEUES];
   link_type          tail_ff [NUM_QUEUES];
   link_type          tail_in [NUM_QUEUES];
   logic [POOL_ENTRIES-1:0] vld_ff, vld_in;
   entry_type         raddr_ff, raddr_in;
   entry_type         res_entry_ff, res_entry_in;
   logic              res_ok_ff, res_ok_in;
   len_type           res_len_ff, res_len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   entry_type         rsp_entry_ff, rsp_entry_in;
   logic              rsp_ok_ff, rsp_ok_in;
   len_type           rsp_len_ff, rsp_len_in;

   logic              wr_en;
   entry_type         wr_addr;
   link_type          wr_data;
   logic              rd_en;
   entry_type         rd_addr;
   link_type          ram_rdata;
   link_type          link_rd;
   link_type          head_cur;
   link_type          tail_cur;
   link_type          e_link;

   llqm_ram #(
      .WIDTH(LINK_W),
      .DEPTH(POOL_ENTRIES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // entries never written still hold their reset chain value
   assign link_rd  = vld_ff[raddr_ff] ? ram_rdata : link_type'(raddr_ff) + link_type'(1);
   assign head_cur = head_ff[qidx_ff];
   assign tail_cur = tail_ff[qidx_ff];
   assign e_link   = link_type'(entry_ff);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      qidx_in      = qidx_ff;
      entry_in     = entry_ff;
      rej_in       = rej_ff;
      t_in         = t_ff;
      cnt_in       = cnt_ff;
      free_head_in = free_head_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      raddr_in     = raddr_ff;
      res_entry_in = res_entry_ff;
      res_ok_in    = res_ok_ff;
      res_len_in   = res_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_entry_in = rsp_entry_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_len_in   = rsp_len_ff;
      pkt_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = entry_ff;
      wr_data      = LINK_NONE;
      rd_en        = 1'b0;
      rd_addr      = entry_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pkt_valid) begin
               pkt_pop      = 1'b1;
               cmd_in       = pkt.cmd;
               qidx_in      = pkt.qidx;
               entry_in     = pkt.entry;
               rej_in       = pkt.reject;
               res_entry_in = '0;
               res_ok_in    = 1'b0;
               res_len_in   = '0;
               state_in     = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_FIN;
            if (!rej_ff) begin
               case (cmd_ff)
                  CMD_ALLOC: begin
                     if (link_valid(free_head_ff)) begin
                        rd_en    = 1'b1;
                        rd_addr  = free_head_ff[ENTRY_W-1:0];
                        t_in     = free_head_ff;
                        state_in = ST_POPRD;
                     end
                  end
                  CMD_POP: begin
                     if (link_valid(head_cur)) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_cur[ENTRY_W-1:0];
                        t_in     = head_cur;
                        state_in = ST_POPRD;
                     end
                  end
                  CMD_RELEASE: begin
                     wr_en        = 1'b1;
                     wr_data      = free_head_ff;
                     free_head_in = e_link;
                     res_ok_in    = 1'b1;
                  end
                  CMD_INSERT: begin
                     wr_en   = 1'b1;
                     wr_data = head_cur;
                     if (!link_valid(head_cur)) begin
                        tail_in[qidx_ff] = e_link;
                     end
                     head_in[qidx_ff] = e_link;
                     res_ok_in        = 1'b1;
                  end
                  CMD_APPEND: begin
                     wr_en            = 1'b1;
                     wr_data          = LINK_NONE;
                     tail_in[qidx_ff] = e_link;
                     res_ok_in        = 1'b1;
                     if (!link_valid(head_cur)) begin
                        head_in[qidx_ff] = e_link;
                     end else if (link_valid(tail_cur)) begin
                        // old tail still needs its link pointed at the entry
                        t_in     = tail_cur;
                        state_in = ST_APP2;
                     end
                  end
                  CMD_REMOVE: begin
                     if (e_link == head_cur) begin
                        rd_en    = 1'b1;
                        rd_addr  = entry_ff;
                        state_in = ST_RMHEAD;
                     end else if (link_valid(head_cur)) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_cur[ENTRY_W-1:0];
                        t_in     = head_cur;
                        cnt_in   = '0;
                        state_in = ST_WALK;
                     end
                  end
                  CMD_LENGTH: begin
                     res_ok_in = 1'b1;
                     if (link_valid(head_cur)) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_cur[ENTRY_W-1:0];
                        cnt_in   = len_type'(1);
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         ST_POPRD: begin
            res_entry_in = t_ff[ENTRY_W-1:0];
            res_ok_in    = 1'b1;
            if (cmd_ff == CMD_ALLOC) begin
               free_head_in = link_valid(link_rd) ? link_rd : LINK_NONE;
            end else if (link_valid(link_rd)) begin
               head_in[qidx_ff] = link_rd;
            end else begin
               head_in[qidx_ff] = LINK_NONE;
               tail_in[qidx_ff] = LINK_NONE;
            end
            state_in = ST_FIN;
         end

         ST_APP2: begin
            wr_en    = 1'b1;
            wr_addr  = t_ff[ENTRY_W-1:0];
            wr_data  = e_link;
            state_in = ST_FIN;
         end

         ST_RMHEAD: begin
            if (e_link == tail_cur) begin
               head_in[qidx_ff] = LINK_NONE;
               tail_in[qidx_ff] = LINK_NONE;
            end else begin
               head_in[qidx_ff] = link_rd;
            end
            wr_en     = 1'b1;
            wr_data   = LINK_NONE;
            res_ok_in = 1'b1;
            state_in  = ST_FIN;
         end

         ST_WALK: begin
            if (cmd_ff == CMD_LENGTH) begin
               if (!link_valid(link_rd) || cnt_ff == len_type'(POOL_ENTRIES)) begin
                  res_len_in = cnt_ff;
                  state_in   = ST_FIN;
               end else begin
                  cnt_in  = cnt_ff + len_type'(1);
                  rd_en   = 1'b1;
                  rd_addr = link_rd[ENTRY_W-1:0];
               end
            end else begin
               // t_ff is the candidate predecessor, link_rd its successor
               if (link_rd == e_link) begin
                  rd_en    = 1'b1;
                  rd_addr  = entry_ff;
                  state_in = ST_RMFIX;
               end else if (cnt_ff == len_type'(POOL_ENTRIES - 1) || !link_valid(link_rd)) begin
                  state_in = ST_FIN;
               end else begin
                  cnt_in  = cnt_ff + len_type'(1);
                  t_in    = link_rd;
                  rd_en   = 1'b1;
                  rd_addr = link_rd[ENTRY_W-1:0];
               end
            end
         end

         ST_RMFIX: begin
            wr_en    = 1'b1;
            wr_addr  = t_ff[ENTRY_W-1:0];
            wr_data  = link_rd;
            state_in = ST_RMCLR;
         end

         ST_RMCLR: begin
            wr_en   = 1'b1;
            wr_data = LINK_NONE;
            if (e_link == tail_cur) begin
               tail_in[qidx_ff] = t_ff;
            end
            res_ok_in = 1'b1;
            state_in  = ST_FIN;
         end

         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = res_entry_ff;
               rsp_ok_in    = res_ok_ff;
               rsp_len_in   = res_len_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rd_en) begin
         raddr_in = rd_addr;
      end

      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      qidx_ff      <= qidx_in;
      entry_ff     <= entry_in;
      rej_ff       <= rej_in;
      t_ff         <= t_in;
      cnt_ff       <= cnt_in;
      raddr_ff     <= raddr_in;
      res_entry_ff <= res_entry_in;
      res_ok_ff    <= res_ok_in;
      res_len_ff   <= res_len_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_len_ff   <= rsp_len_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= LINK_NONE;
            tail_ff[i] <= LINK_NONE;
         end
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_out    = rsp_entry_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_queue_length = rsp_len_ff;

endmodule

/* design/linked_list_queue_manager.sv */
// ----------------------------------------------------------------------------
// linked_list_queue_manager
// Pool of entries threaded into several singly linked queues and a free list.
//
//   channel   direction  ports                                    beat
//   req       in         req_command, req_queue_id, req_entry     one command
//   rsp       out        rsp_entry_out, rsp_ok, rsp_queue_length  one result
//
// alloc and pop read the link RAM in EXEC and update the head in POPRD;
// release and insert write it in EXEC; append to a non-empty queue also
// links the old tail in APP2; FIN then loads the output register.
// length and remove walk the link RAM one link per cycle through its single
// read port. link RAM entries never written read as the reset chain through
// per-entry valid bits, so no clearing pass is run.
// a two-deep command queue takes beats while the back end works or while a
// result waits in the output register.
// ----------------------------------------------------------------------------
module linked_list_queue_manager
   import llqm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [QID_W-1:0]   req_queue_id,
   input  logic [ENTRY_W-1:0] req_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ENTRY_W-1:0] rsp_entry_out,
   output logic               rsp_ok,
   output logic [LEN_W-1:0]   rsp_queue_length
);

   cmd_pkt_type pkt;
   logic        pkt_valid;
   logic        pkt_pop;

   llqm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_queue_id (req_queue_id),
      .req_entry    (req_entry),
      .pkt_valid    (pkt_valid),
      .pkt_pop      (pkt_pop),
      .pkt          (pkt)
   );

   llqm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pkt_valid        (pkt_valid),
      .pkt_pop          (pkt_pop),
      .pkt              (pkt),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_out    (rsp_entry_out),
      .rsp_ok           (rsp_ok),
      .rsp_queue_length (rsp_queue_length)
   );

endmodule

/* design/llqm_checker.sv */
// ----------------------------------------------------------------------------
// llqm_checker
// Port-level checks on the result channel of the queue manager.
// ----------------------------------------------------------------------------
module llqm_checker
   import llqm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [ENTRY_W-1:0] rsp_entry_out,
   input  logic               rsp_ok,
   input  logic [LEN_W-1:0]   rsp_queue_length
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_out)
         && $stable(rsp_ok) && $stable(rsp_queue_length))
      else $error("result beat changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a failed command never reports an entry
   a_fail_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_entry_out == '0 && rsp_queue_length == '0)
      else $error("failed result carries data");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queue_length <= LEN_W'(POOL_ENTRIES))
      else $error("queue length beyond pool size");

   // a length count and a returned entry never come together
   a_len_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_length != '0 |-> rsp_entry_out == '0)
      else $error("length result carries an entry");

endmodule

bind linked_list_queue_manager llqm_checker u_llqm_checker (.*);
